// ===== rtl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// lms_pkg
// Shared widths, constants, types and saturation helper for the LMS trainer.
// ----------------------------------------------------------------------------
package lms_pkg;

    // Q(DATA_W-FRAC_BITS).FRAC_BITS data, unsigned Q0.RATE_BITS learning rate
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int RATE_BITS = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (DATA_W > RATE_BITS) ? DATA_W : RATE_BITS;

    // Datapath widths
    localparam int PROD_W    = 2 * DATA_W;             // sample * weight
    localparam int SUM_W     = PROD_W + 1;             // sum of two products
    localparam int SUM_RND_W = SUM_W + 1;              // plus rounding half
    localparam int RP_W      = RATE_BITS + 1 + DATA_W; // rate * error
    localparam int RP_RND_W  = RP_W + 1;
    localparam int RE_W      = RP_RND_W - RATE_BITS;   // scaled error step
    localparam int DP_W      = RE_W + DATA_W;          // step * sample
    localparam int DP_RND_W  = DP_W + 1;
    localparam int WIDE_W    = 2 * DATA_W + RATE_BITS + 2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(DATA_MAX);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(DATA_MIN);

    // 1.0, or the largest positive value if 1.0 does not fit
    localparam logic signed [DATA_W-1:0] ONE_VALUE =
        (FRAC_BITS >= DATA_W - 1) ? DATA_MAX : DATA_W'(longint'(1) << FRAC_BITS);

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(13107);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARN_RATE      = 2'd0,
        REG_INIT_WEIGHT_ONE = 2'd1,
        REG_INIT_WEIGHT_TWO = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRODUCT,
        ST_ERROR,
        ST_RATE,
        ST_DELTA,
        ST_UPDATE
    } lms_state_t;

    typedef struct packed {
        logic load_item;
        logic product;
        logic calc_error;
        logic rate;
        logic delta;
        logic update;
    } lms_cmd_t;

    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [DATA_W-1:0] r;
        if (x > WIDE_MAX)
        begin
            r = DATA_MAX;
        end
        else if (x < WIDE_MIN)
        begin
            r = DATA_MIN;
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lms_in_if.sv =====
// ----------------------------------------------------------------------------
// lms_in_if
// Training sample channel: two samples, target and restart flag.
// ----------------------------------------------------------------------------
interface lms_in_if;
    import lms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_one;
    logic signed [DATA_W-1:0] sample_two;
    logic signed [DATA_W-1:0] target_value;
    logic                     restart;

    modport source (output valid, sample_one, sample_two, target_value, restart,
                    input ready);
    modport sink   (input valid, sample_one, sample_two, target_value, restart,
                    output ready);
endinterface

// ===== rtl/lms_out_if.sv =====
// ----------------------------------------------------------------------------
// lms_out_if
// Result channel: neuron output and error.
// ----------------------------------------------------------------------------
interface lms_out_if;
    import lms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] neuron_output;
    logic signed [DATA_W-1:0] output_error;

    modport source (output valid, neuron_output, output_error, input ready);
    modport sink   (input valid, neuron_output, output_error, output ready);
endinterface

// ===== rtl/lms_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lms_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lms_cfg_if;
    import lms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/lms_ctrl.sv =====
// ----------------------------------------------------------------------------
// lms_ctrl
// Sequencer for one training word: product, error, rate, delta, update.
// ----------------------------------------------------------------------------
module lms_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output lms_pkg::lms_cmd_t cmd
);
    import lms_pkg::*;

    lms_state_t state_reg;
    lms_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PRODUCT;
                end
            end
            ST_PRODUCT:
            begin
                cmd.product = 1'b1;
                state_next  = ST_ERROR;
            end
            ST_ERROR:
            begin
                cmd.calc_error = 1'b1;
                state_next     = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_update_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("result word not presented after update");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PRODUCT))
        else $error("accepted word did not start processing");

endmodule

// ===== rtl/lms_dp.sv =====
// ----------------------------------------------------------------------------
// lms_dp
// Datapath: registers, weights, multipliers, rounding and saturation.
// ----------------------------------------------------------------------------
module lms_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lms_pkg::lms_cmd_t                 cmd,
    input  logic signed [lms_pkg::DATA_W-1:0] sample_one,
    input  logic signed [lms_pkg::DATA_W-1:0] sample_two,
    input  logic signed [lms_pkg::DATA_W-1:0] target_value,
    input  logic                              restart,
    input  logic                              cfg_write,
    input  logic [lms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic signed [lms_pkg::DATA_W-1:0] neuron_output,
    output logic signed [lms_pkg::DATA_W-1:0] output_error
);
    import lms_pkg::*;

    localparam logic signed [SUM_RND_W-1:0] OUT_HALF  = SUM_RND_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [RP_RND_W-1:0]  RATE_HALF = RP_RND_W'(1) << (RATE_BITS - 1);
    localparam logic signed [DP_RND_W-1:0]  DLT_HALF  = DP_RND_W'(1) << (FRAC_BITS - 1);

    // configuration and weights
    logic        [RATE_BITS-1:0] learn_rate_reg;
    logic signed [DATA_W-1:0]    init_w1_reg;
    logic signed [DATA_W-1:0]    init_w2_reg;
    logic signed [DATA_W-1:0]    w1_reg;
    logic signed [DATA_W-1:0]    w2_reg;
    logic signed [DATA_W-1:0]    w1_next;
    logic signed [DATA_W-1:0]    w2_next;

    // payload
    logic signed [DATA_W-1:0] s1_reg;
    logic signed [DATA_W-1:0] s2_reg;
    logic signed [DATA_W-1:0] tg_reg;
    logic signed [PROD_W-1:0] prod1_reg;
    logic signed [PROD_W-1:0] prod2_reg;
    logic signed [DATA_W-1:0] out_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [RE_W-1:0]   re_reg;
    logic signed [DP_W-1:0]   dprod1_reg;
    logic signed [DP_W-1:0]   dprod2_reg;
    logic signed [DATA_W-1:0] res_out_reg;
    logic signed [DATA_W-1:0] res_err_reg;

    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_RND_W-1:0] sum_rnd;
    logic signed [SUM_RND_W-1:0] sum_shift;
    logic signed [DATA_W-1:0]    out_next;
    logic signed [DATA_W-1:0]    err_next;
    logic signed [RP_W-1:0]      rate_prod;
    logic signed [RP_RND_W-1:0]  rate_rnd;
    logic signed [RP_RND_W-1:0]  rate_shift;
    logic signed [DP_RND_W-1:0]  d1_rnd;
    logic signed [DP_RND_W-1:0]  d2_rnd;
    logic signed [DP_RND_W-1:0]  d1_shift;
    logic signed [DP_RND_W-1:0]  d2_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= RATE_RESET;
            init_w1_reg    <= ONE_VALUE;
            init_w2_reg    <= ONE_VALUE;
            w1_reg         <= ONE_VALUE;
            w2_reg         <= ONE_VALUE;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LEARN_RATE:      learn_rate_reg <= cfg_data[RATE_BITS-1:0];
                    REG_INIT_WEIGHT_ONE: init_w1_reg    <= cfg_data[DATA_W-1:0];
                    REG_INIT_WEIGHT_TWO: init_w2_reg    <= cfg_data[DATA_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.load_item && restart)
            begin
                w1_reg <= init_w1_reg;
                w2_reg <= init_w2_reg;
            end
            else if (cmd.update)
            begin
                w1_reg <= w1_next;
                w2_reg <= w2_next;
            end
        end
    end

    // output = round(s1*w1 + s2*w2), error = target - output
    always_comb
    begin
        sum       = SUM_W'(prod1_reg) + SUM_W'(prod2_reg);
        sum_rnd   = SUM_RND_W'(sum) + OUT_HALF;
        sum_shift = sum_rnd >>> FRAC_BITS;
        out_next  = sat_data(WIDE_W'(sum_shift));
        err_next  = sat_data(WIDE_W'(tg_reg) - WIDE_W'(out_next));
    end

    // step = round(rate * error >> RATE_BITS)
    always_comb
    begin
        rate_prod  = $signed({1'b0, learn_rate_reg}) * err_reg;
        rate_rnd   = RP_RND_W'(rate_prod) + RATE_HALF;
        rate_shift = rate_rnd >>> RATE_BITS;
    end

    // weight += round(step * sample >> FRAC_BITS), saturated
    always_comb
    begin
        d1_rnd   = DP_RND_W'(dprod1_reg) + DLT_HALF;
        d2_rnd   = DP_RND_W'(dprod2_reg) + DLT_HALF;
        d1_shift = d1_rnd >>> FRAC_BITS;
        d2_shift = d2_rnd >>> FRAC_BITS;
        w1_next  = sat_data(WIDE_W'(w1_reg) + WIDE_W'(d1_shift));
        w2_next  = sat_data(WIDE_W'(w2_reg) + WIDE_W'(d2_shift));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            s1_reg <= sample_one;
            s2_reg <= sample_two;
            tg_reg <= target_value;
        end
        if (cmd.product)
        begin
            prod1_reg <= s1_reg * w1_reg;
            prod2_reg <= s2_reg * w2_reg;
        end
        if (cmd.calc_error)
        begin
            out_reg <= out_next;
            err_reg <= err_next;
        end
        if (cmd.rate)
        begin
            re_reg <= rate_shift[RE_W-1:0];
        end
        if (cmd.delta)
        begin
            dprod1_reg <= re_reg * s1_reg;
            dprod2_reg <= re_reg * s2_reg;
        end
        if (cmd.update)
        begin
            res_out_reg <= out_reg;
            res_err_reg <= err_reg;
        end
    end

    assign neuron_output = res_out_reg;
    assign output_error  = res_err_reg;

endmodule

// ===== rtl/two_input_lms_neuron_trainer.sv =====
// A result word is registered and valid after the product, error, rate, delta
// and update states; update waits while a result is unread. Weight update of
// one word completes before the next word is accepted, as set by the dependent
// chain product -> rate * error -> step * sample through the shared datapath.
// Reset (rst_n low, asynchronous): learning rate 13107, initial and working
// weights 1.0, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// two_input_lms_neuron_trainer
// Online delta-rule trainer for a two-input linear neuron.
// ----------------------------------------------------------------------------
module two_input_lms_neuron_trainer
(
    input  logic      clk,
    input  logic      rst_n,
    lms_in_if.sink    item,
    lms_out_if.source result,
    lms_cfg_if.sink   cfg
);
    import lms_pkg::*;

    lms_cmd_t cmd;

    assign cfg.ready = 1'b1;

    lms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    lms_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample_one    (item.sample_one),
        .sample_two    (item.sample_two),
        .target_value  (item.target_value),
        .restart       (item.restart),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.reg_index),
        .cfg_data      (cfg.data),
        .neuron_output (result.neuron_output),
        .output_error  (result.output_error)
    );

endmodule
